// ===== src/usmg_pkg.sv =====
// package: shared types, constants and tables for the uv sphere mesh generator
package usmg_pkg;

  localparam int unsigned MaxStacksDef   = 64;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned RadiusReset    = 256;
  localparam int unsigned StackReset     = 16;

  localparam logic [0:0] CfgRadius = 1'b0;
  localparam logic [0:0] CfgStacks = 1'b1;

  localparam logic [1:0] KindVertex = 2'd0;
  localparam logic [1:0] KindFace   = 2'd1;
  localparam logic [1:0] KindLast   = 2'd2;
  localparam logic [1:0] KindIdle   = 2'd3;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RING, PH_BOTPOLE, PH_TOPFACE, PH_INNER, PH_BOTFACE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CORDIC, ST_MUL1, ST_MUL2, ST_OUT
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic div_start;
    logic cordic_start;
    logic mul1;
    logic mul2;
    logic load_vertex;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic cordic_done;
  } dp_sts_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] k);
    logic signed [33:0] r;
    begin
      unique case (k)
        5'd0: r = 34'sh20000000;  5'd1: r = 34'sh12E4051E;
        5'd2: r = 34'sh09FB385B;  5'd3: r = 34'sh051111D4;
        5'd4: r = 34'sh028B0D43;  5'd5: r = 34'sh0145D7E1;
        5'd6: r = 34'sh00A2F61E;  5'd7: r = 34'sh00517C55;
        5'd8: r = 34'sh0028BE53;  5'd9: r = 34'sh00145F2F;
        5'd10: r = 34'sh000A2F98; 5'd11: r = 34'sh000517CC;
        5'd12: r = 34'sh00028BE6; 5'd13: r = 34'sh000145F3;
        5'd14: r = 34'sh0000A2FA; 5'd15: r = 34'sh0000517D;
        5'd16: r = 34'sh000028BE; 5'd17: r = 34'sh0000145F;
        5'd18: r = 34'sh00000A30; 5'd19: r = 34'sh00000518;
        5'd20: r = 34'sh0000028C; 5'd21: r = 34'sh00000146;
        5'd22: r = 34'sh000000A3; 5'd23: r = 34'sh00000051;
        5'd24: r = 34'sh00000029; 5'd25: r = 34'sh00000014;
        5'd26: r = 34'sh0000000A; 5'd27: r = 34'sh00000005;
        5'd28: r = 34'sh00000003; 5'd29: r = 34'sh00000001;
        default: r = 34'sh0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/usmg_datapath.sv =====
// datapath: angle division, cordic for two angles, radius scaling and vertex fields
module usmg_datapath #(
  parameter int unsigned CORDIC_STEPS = usmg_pkg::CordicStepsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  usmg_pkg::dp_cmd_t      cmd,
  output usmg_pkg::dp_sts_t      sts,
  input  logic [6:0]             ring_i,
  input  logic [6:0]             slice_j,
  input  logic [7:0]             s_val,
  input  logic [15:0]            rad,
  output logic signed [16:0]     v_px,
  output logic signed [16:0]     v_py,
  output logic signed [16:0]     v_pz,
  output logic signed [15:0]     v_nx,
  output logic signed [15:0]     v_ny,
  output logic signed [15:0]     v_nz,
  output logic [16:0]            v_u,
  output logic [16:0]            v_v
);

  localparam int unsigned SW = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int unsigned KW = $clog2(SW + 1);
  localparam int unsigned NW = 40;

  // restoring divider shared by four quotients, one bit per cycle
  logic [1:0]    dsel_r, dsel_nxt;
  logic [5:0]    dbit_r, dbit_nxt;
  logic [NW-1:0] drem_r, drem_nxt, dnum_r, dnum_nxt;
  logic [31:0]   dq_r, dq_nxt;
  logic          dbusy_r, dbusy_nxt, ddone_r, ddone_nxt;
  logic [31:0]   aphi_r, ath_r, qu_r, qv_r;
  logic [31:0]   aphi_nxt, ath_nxt, qu_nxt, qv_nxt;
  logic [NW-1:0] half_s, dtrial;

  assign half_s = NW'(s_val >> 1);

  function automatic logic [NW-1:0] dnum_of(input logic [1:0] sel, input logic [6:0] i,
                                           input logic [6:0] j, input logic [NW-1:0] h);
    logic [NW-1:0] r;
    begin
      unique case (sel)
        2'd0: r = (NW'(i) << 31) + h;
        2'd1: r = (NW'(j) << 32) + h;
        2'd2: r = (NW'(j) << 16) + h;
        default: r = (NW'(i) << 16) + h;
      endcase
      return r;
    end
  endfunction

  always_comb begin
    dsel_nxt = dsel_r; dbit_nxt = dbit_r; drem_nxt = drem_r; dnum_nxt = dnum_r;
    dq_nxt = dq_r; dbusy_nxt = dbusy_r; ddone_nxt = 1'b0;
    aphi_nxt = aphi_r; ath_nxt = ath_r; qu_nxt = qu_r; qv_nxt = qv_r;
    dtrial = {drem_r[NW-2:0], dnum_r[NW-1]} - NW'(s_val);
    if (cmd.div_start) begin
      dsel_nxt = 2'd0; dbit_nxt = '0; drem_nxt = '0; dq_nxt = '0; dbusy_nxt = 1'b1;
      dnum_nxt = dnum_of(2'd0, ring_i, slice_j, half_s);
    end else if (dbusy_r) begin
      dnum_nxt = {dnum_r[NW-2:0], 1'b0};
      if ({drem_r[NW-2:0], dnum_r[NW-1]} >= NW'(s_val)) begin
        drem_nxt = dtrial;
        dq_nxt = {dq_r[30:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[NW-2:0], dnum_r[NW-1]};
        dq_nxt = {dq_r[30:0], 1'b0};
      end
      dbit_nxt = dbit_r + 6'd1;
      if (dbit_r == 6'(NW - 1)) begin
        unique case (dsel_r)
          2'd0: aphi_nxt = dq_nxt;
          2'd1: ath_nxt = dq_nxt;
          2'd2: qu_nxt = dq_nxt;
          default: qv_nxt = dq_nxt;
        endcase
        dbit_nxt = '0; drem_nxt = '0; dq_nxt = '0;
        dsel_nxt = dsel_r + 2'd1;
        dnum_nxt = dnum_of(dsel_r + 2'd1, ring_i, slice_j, half_s);
        if (dsel_r == 2'd3) begin
          dbusy_nxt = 1'b0; ddone_nxt = 1'b1;
        end
      end
    end
  end

  // two cordic rotators in parallel, one micro-rotation per cycle
  logic signed [33:0] x0_r, y0_r, z0_r, x1_r, y1_r, z1_r;
  logic signed [33:0] x0_nxt, y0_nxt, z0_nxt, x1_nxt, y1_nxt, z1_nxt;
  logic               f0_r, f1_r, f0_nxt, f1_nxt;
  logic [KW-1:0]      ck_r, ck_nxt;
  logic               cbusy_r, cbusy_nxt, cdone_r, cdone_nxt;
  logic [31:0]        a0, a1;
  logic signed [33:0] at;

  always_comb begin
    x0_nxt = x0_r; y0_nxt = y0_r; z0_nxt = z0_r;
    x1_nxt = x1_r; y1_nxt = y1_r; z1_nxt = z1_r;
    f0_nxt = f0_r; f1_nxt = f1_r; ck_nxt = ck_r;
    cbusy_nxt = cbusy_r; cdone_nxt = 1'b0;
    a0 = aphi_r; a1 = ath_r;
    at = usmg_pkg::atan_entry(5'(ck_r));
    if (cmd.cordic_start) begin
      f0_nxt = a0[31] ^ a0[30];
      f1_nxt = a1[31] ^ a1[30];
      a0[31] = a0[31] ^ f0_nxt;
      a1[31] = a1[31] ^ f1_nxt;
      x0_nxt = usmg_pkg::CordicGain; y0_nxt = '0; z0_nxt = 34'(signed'(a0));
      x1_nxt = usmg_pkg::CordicGain; y1_nxt = '0; z1_nxt = 34'(signed'(a1));
      ck_nxt = '0; cbusy_nxt = 1'b1;
    end else if (cbusy_r) begin
      if (!z0_r[33]) begin
        x0_nxt = x0_r - (y0_r >>> ck_r); y0_nxt = y0_r + (x0_r >>> ck_r); z0_nxt = z0_r - at;
      end else begin
        x0_nxt = x0_r + (y0_r >>> ck_r); y0_nxt = y0_r - (x0_r >>> ck_r); z0_nxt = z0_r + at;
      end
      if (!z1_r[33]) begin
        x1_nxt = x1_r - (y1_r >>> ck_r); y1_nxt = y1_r + (x1_r >>> ck_r); z1_nxt = z1_r - at;
      end else begin
        x1_nxt = x1_r + (y1_r >>> ck_r); y1_nxt = y1_r - (x1_r >>> ck_r); z1_nxt = z1_r + at;
      end
      ck_nxt = ck_r + KW'(1);
      if (ck_r == KW'(SW - 1)) begin
        cbusy_nxt = 1'b0; cdone_nxt = 1'b1;
      end
    end
  end

  logic signed [33:0] cp, sp, ct, st;
  assign cp = f0_r ? -x0_r : x0_r;
  assign sp = f0_r ? -y0_r : y0_r;
  assign ct = f1_r ? -x1_r : x1_r;
  assign st = f1_r ? -y1_r : y1_r;

  // first multiply: normal products; second: radius scaling
  logic signed [33:0] nx_r, nz_r, cpr_r;
  logic signed [67:0] mx, mz;
  logic signed [51:0] px_r, py_r, pz_r;
  logic signed [51:0] rad_s;

  assign mx = sp * ct;
  assign mz = sp * st;
  assign rad_s = 52'(signed'({1'b0, rad}));

  function automatic logic signed [33:0] rnd30(input logic signed [67:0] v);
    logic signed [67:0] t;
    begin
      t = (v + 68'sd536870912) >>> 30;
      return 34'(t);
    end
  endfunction

  function automatic logic signed [16:0] pos_of(input logic signed [51:0] p);
    logic signed [51:0] t;
    begin
      t = (p + 52'sd536870912) >>> 30;
      if (t > 52'sd65535) return 17'sd65535;
      if (t < -52'sd65535) return -17'sd65535;
      return 17'(t);
    end
  endfunction

  function automatic logic signed [15:0] nrm_of(input logic signed [33:0] n);
    logic signed [33:0] t;
    begin
      t = (n + 34'sd32768) >>> 16;
      if (t > 34'sd16384) return 16'sd16384;
      if (t < -34'sd16384) return -16'sd16384;
      return 16'(t);
    end
  endfunction

  logic [15:0] u_raw;
  assign u_raw = 16'd49152 - qu_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; ddone_r <= 1'b0; cbusy_r <= 1'b0; cdone_r <= 1'b0;
    end else begin
      dbusy_r <= dbusy_nxt; ddone_r <= ddone_nxt;
      cbusy_r <= cbusy_nxt; cdone_r <= cdone_nxt;
    end
    dsel_r <= dsel_nxt; dbit_r <= dbit_nxt; drem_r <= drem_nxt; dnum_r <= dnum_nxt;
    dq_r <= dq_nxt; aphi_r <= aphi_nxt; ath_r <= ath_nxt; qu_r <= qu_nxt; qv_r <= qv_nxt;
    x0_r <= x0_nxt; y0_r <= y0_nxt; z0_r <= z0_nxt;
    x1_r <= x1_nxt; y1_r <= y1_nxt; z1_r <= z1_nxt;
    f0_r <= f0_nxt; f1_r <= f1_nxt; ck_r <= ck_nxt;
    if (cmd.mul1) begin
      nx_r <= rnd30(mx); nz_r <= rnd30(mz); cpr_r <= cp;
    end
    if (cmd.mul2) begin
      px_r <= rad_s * 52'(nx_r); py_r <= rad_s * 52'(cpr_r); pz_r <= rad_s * 52'(nz_r);
    end
    if (cmd.load_vertex) begin
      v_px <= pos_of(px_r); v_py <= pos_of(py_r); v_pz <= pos_of(pz_r);
      v_nx <= nrm_of(nx_r); v_ny <= nrm_of(cpr_r); v_nz <= nrm_of(nz_r);
      v_u <= {1'b0, u_raw};
      v_v <= 17'(18'd65536 - 18'(qv_r));
    end
  end

  assign sts.div_done = ddone_r;
  assign sts.cordic_done = cdone_r;

endmodule

// ===== src/usmg_controller.sv =====
// controller: mesh sequencing, face indices, handshake and vertex compute sequencing
module usmg_controller #(
  parameter int unsigned MAX_STACKS = usmg_pkg::MaxStacksDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic                out_is_vtx,
  output logic                out_is_pole,
  output logic                out_pole_south,
  output logic [12:0]         out_corner_a,
  output logic [12:0]         out_corner_b,
  output logic [12:0]         out_corner_c,
  input  logic [6:0]          stack_count,
  output usmg_pkg::dp_cmd_t   cmd,
  input  usmg_pkg::dp_sts_t   sts,
  output logic [6:0]          ring_i,
  output logic [6:0]          slice_j,
  output logic [7:0]          s_val,
  output logic                lat_r_en
);

  usmg_pkg::ctl_state_t st_r, st_nxt;
  usmg_pkg::phase_t     ph_r, ph_nxt;
  logic [6:0]  ring_r, ring_nxt, slc_r, slc_nxt;
  logic        sec_r, sec_nxt;
  logic [7:0]  s_r, s_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        isv_r, isv_nxt, isp_r, isp_nxt, sth_r, sth_nxt;
  logic [12:0] ca_r, cb_r, cc_r, ca_nxt, cb_nxt, cc_nxt;
  logic [15:0] rv, a, south, s_clamp;
  logic        take;

  assign in_stall = (st_r != usmg_pkg::ST_IDLE) || (ov_r && out_stall);
  assign take = in_valid && !in_stall;
  assign rv = 16'(s_r) + 16'd1;
  assign a = 16'd1 + 16'(ring_r) * rv + 16'(slc_r);
  assign south = 16'(s_r) * 16'(s_r);

  always_comb begin
    if (stack_count < 7'd2) s_clamp = 16'd2;
    else if (16'(stack_count) > 16'(MAX_STACKS)) s_clamp = 16'(MAX_STACKS);
    else s_clamp = 16'(stack_count);
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; ring_nxt = ring_r; slc_nxt = slc_r; sec_nxt = sec_r;
    s_nxt = s_r; ov_nxt = ov_r; kind_nxt = kind_r; isv_nxt = isv_r; isp_nxt = isp_r;
    sth_nxt = sth_r; ca_nxt = ca_r; cb_nxt = cb_r; cc_nxt = cc_r;
    cmd = '0; lat_r_en = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      usmg_pkg::ST_IDLE: begin
        if (take) begin
          kind_nxt = usmg_pkg::KindFace; isv_nxt = 1'b0; isp_nxt = 1'b0; sth_nxt = 1'b0;
          ca_nxt = '0; cb_nxt = '0; cc_nxt = '0;
          ov_nxt = 1'b1;
          if (in_restart) begin
            s_nxt = s_clamp[7:0]; lat_r_en = 1'b1;
            kind_nxt = usmg_pkg::KindVertex; isv_nxt = 1'b1; isp_nxt = 1'b1;
            ph_nxt = usmg_pkg::PH_RING; ring_nxt = 7'd1; slc_nxt = '0; sec_nxt = 1'b0;
          end else begin
            unique case (ph_r)
              usmg_pkg::PH_RING: begin
                ov_nxt = 1'b0; kind_nxt = usmg_pkg::KindVertex; isv_nxt = 1'b1;
                cmd.div_start = 1'b1; st_nxt = usmg_pkg::ST_DIV;
              end
              usmg_pkg::PH_BOTPOLE: begin
                kind_nxt = usmg_pkg::KindVertex; isv_nxt = 1'b1; isp_nxt = 1'b1;
                sth_nxt = 1'b1; ph_nxt = usmg_pkg::PH_TOPFACE; slc_nxt = 7'd1;
              end
              usmg_pkg::PH_TOPFACE: begin
                cb_nxt = 13'(slc_r + 7'd1); cc_nxt = 13'(slc_r);
                slc_nxt = slc_r + 7'd1;
                if (8'(slc_r) + 8'd1 > s_r) begin
                  slc_nxt = '0; ring_nxt = '0; sec_nxt = 1'b0;
                  ph_nxt = (s_r >= 8'd3) ? usmg_pkg::PH_INNER : usmg_pkg::PH_BOTFACE;
                end
              end
              usmg_pkg::PH_INNER: begin
                if (!sec_r) begin
                  ca_nxt = a[12:0]; cb_nxt = 13'(a + 16'd1); cc_nxt = 13'(a + rv);
                  sec_nxt = 1'b1;
                end else begin
                  ca_nxt = 13'(a + rv); cb_nxt = 13'(a + 16'd1);
                  cc_nxt = 13'(a + rv + 16'd1);
                  sec_nxt = 1'b0; slc_nxt = slc_r + 7'd1;
                  if (8'(slc_r) + 8'd1 >= s_r) begin
                    slc_nxt = '0; ring_nxt = ring_r + 7'd1;
                    if (8'(ring_r) + 8'd1 >= s_r - 8'd2) ph_nxt = usmg_pkg::PH_BOTFACE;
                  end
                end
              end
              usmg_pkg::PH_BOTFACE: begin
                ca_nxt = south[12:0];
                cb_nxt = 13'(south - rv + 16'(slc_r));
                cc_nxt = 13'(south - rv + 16'(slc_r) + 16'd1);
                if (8'(slc_r) + 8'd1 >= s_r) begin
                  kind_nxt = usmg_pkg::KindLast; ph_nxt = usmg_pkg::PH_IDLE; slc_nxt = '0;
                end else begin
                  slc_nxt = slc_r + 7'd1;
                end
              end
              default: begin
                kind_nxt = usmg_pkg::KindIdle;
              end
            endcase
          end
        end
      end
      usmg_pkg::ST_DIV: if (sts.div_done) begin
        cmd.cordic_start = 1'b1; st_nxt = usmg_pkg::ST_CORDIC;
      end
      usmg_pkg::ST_CORDIC: if (sts.cordic_done) begin
        cmd.mul1 = 1'b1; st_nxt = usmg_pkg::ST_MUL1;
      end
      usmg_pkg::ST_MUL1: begin
        cmd.mul2 = 1'b1; st_nxt = usmg_pkg::ST_MUL2;
      end
      usmg_pkg::ST_MUL2: begin
        cmd.load_vertex = 1'b1; st_nxt = usmg_pkg::ST_OUT;
      end
      usmg_pkg::ST_OUT: begin
        ov_nxt = 1'b1; st_nxt = usmg_pkg::ST_IDLE;
        slc_nxt = slc_r + 7'd1;
        if (8'(slc_r) + 8'd1 > s_r) begin
          slc_nxt = '0; ring_nxt = ring_r + 7'd1;
          if (8'(ring_r) + 8'd1 > s_r - 8'd1) ph_nxt = usmg_pkg::PH_BOTPOLE;
        end
      end
      default: st_nxt = usmg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= usmg_pkg::ST_IDLE; ph_r <= usmg_pkg::PH_IDLE;
      ring_r <= '0; slc_r <= '0; sec_r <= 1'b0; s_r <= 8'd2; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ring_r <= ring_nxt; slc_r <= slc_nxt;
      sec_r <= sec_nxt; s_r <= s_nxt; ov_r <= ov_nxt;
    end
    kind_r <= kind_nxt; isv_r <= isv_nxt; isp_r <= isp_nxt; sth_r <= sth_nxt;
    ca_r <= ca_nxt; cb_r <= cb_nxt; cc_r <= cc_nxt;
  end

  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_is_vtx = isv_r;
  assign out_is_pole = isp_r;
  assign out_pole_south = sth_r;
  assign out_corner_a = ca_r;
  assign out_corner_b = cb_r;
  assign out_corner_c = cc_r;
  assign ring_i = ring_r;
  assign slice_j = slc_r;
  assign s_val = s_r;

endmodule

// ===== src/uv_sphere_mesh_generator.sv =====
// top level: uv sphere mesh generator, one result item per request item
// Usage:
//   in_valid/in_stall/in_restart carry request items; out_valid/out_stall and
//   the out_ field ports carry result items, one result per request.
//   cfg_we/cfg_index/cfg_data write radius (index 0) and stack_count (index 1);
//   both are latched at a restart request and used for the whole mesh.
//   Poles, faces and idle answers appear in the cycle after the request is taken.
//   A ring vertex runs the shared bit-serial divider for four quotients (its
//   angles and texture coordinates), then the two CORDIC rotators for both
//   angles in parallel, then two multiply steps and one output step; the
//   divider takes most of that time.
//   Only one request is in flight; the result sits in an output register
//   and a new request is taken in the same cycle it is taken away.
//   While out_stall is high a pending result holds and in_stall stays high.
//   Reset clears the sequencer to idle: requests without restart then get
//   an idle answer, and registers return to radius 256 and 16 stacks.
module uv_sphere_mesh_generator #(
  parameter int unsigned MAX_STACKS   = usmg_pkg::MaxStacksDef,
  parameter int unsigned CORDIC_STEPS = usmg_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic [12:0]        out_corner_a,
  output logic [12:0]        out_corner_b,
  output logic [12:0]        out_corner_c,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] radius_r, lat_r_r;
  logic [6:0]  stack_r;
  usmg_pkg::dp_cmd_t cmd;
  usmg_pkg::dp_sts_t sts;
  logic [6:0] ring_i, slice_j;
  logic [7:0] s_val;
  logic lat_r_en, is_vtx, is_pole, pole_s;
  logic signed [16:0] v_px, v_py, v_pz;
  logic signed [15:0] v_nx, v_ny, v_nz;
  logic [16:0] v_u, v_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'(usmg_pkg::RadiusReset);
      stack_r <= 7'(usmg_pkg::StackReset);
      lat_r_r <= '0;
    end else begin
      if (cfg_we && cfg_index == usmg_pkg::CfgRadius) radius_r <= cfg_data;
      if (cfg_we && cfg_index == usmg_pkg::CfgStacks) stack_r <= cfg_data[6:0];
      if (lat_r_en) lat_r_r <= radius_r;
    end
  end

  usmg_controller #(.MAX_STACKS(MAX_STACKS)) u_ctl (
    .clk, .rst_n, .in_valid, .in_stall, .in_restart, .out_valid, .out_stall,
    .out_kind, .out_is_vtx(is_vtx), .out_is_pole(is_pole), .out_pole_south(pole_s),
    .out_corner_a, .out_corner_b, .out_corner_c, .stack_count(stack_r),
    .cmd, .sts, .ring_i, .slice_j, .s_val, .lat_r_en
  );

  usmg_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .ring_i, .slice_j, .s_val, .rad(lat_r_r),
    .v_px, .v_py, .v_pz, .v_nx, .v_ny, .v_nz, .v_u, .v_v
  );

  logic signed [16:0] pole_y;
  assign pole_y = pole_s ? -17'(signed'({1'b0, lat_r_r})) : 17'(signed'({1'b0, lat_r_r}));

  always_comb begin
    out_pos_x = '0; out_pos_y = '0; out_pos_z = '0;
    out_norm_x = '0; out_norm_y = '0; out_norm_z = '0;
    out_tex_u = '0; out_tex_v = '0;
    if (is_vtx && is_pole) begin
      out_pos_y = pole_y;
      out_norm_y = pole_s ? -16'sd16384 : 16'sd16384;
    end else if (is_vtx) begin
      out_pos_x = v_px; out_pos_y = v_py; out_pos_z = v_pz;
      out_norm_x = v_nx; out_norm_y = v_ny; out_norm_z = v_nz;
      out_tex_u = v_u; out_tex_v = v_v;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result waits");
  a_face_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != usmg_pkg::KindVertex |-> out_pos_x == 17'sd0)
    else $error("face carries position");

endmodule
